[hdl/flg_pkg.sv]
// ----------------------------------------------------------------------------
// flg_pkg
// Shared types, register map and constants of the frame load governor.
// ----------------------------------------------------------------------------
package flg_pkg;

  localparam int unsigned AddrWidth = 5;

  typedef enum logic [2:0] {
    REG_EMERG_THR   = 3'd0,
    REG_REDUCED_THR = 3'd1,
    REG_AVG_THR     = 3'd2,
    REG_EMERG_HOLD  = 3'd3,
    REG_LONG_HOLD   = 3'd4,
    REG_SHORT_HOLD  = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    LVL_NORMAL    = 2'd0,
    LVL_REDUCED   = 2'd1,
    LVL_EMERGENCY = 2'd2
  } load_level_e;

  localparam logic [30:0] EmergThrReset   = 31'd40000;
  localparam logic [30:0] ReducedThrReset = 31'd28000;
  localparam logic [30:0] AvgThrReset     = 31'd20000;
  localparam logic [15:0] EmergHoldReset  = 16'd192;
  localparam logic [15:0] LongHoldReset   = 16'd360;
  localparam logic [15:0] ShortHoldReset  = 16'd192;

  // Q16 weights of the moving average, summing to 65536
  localparam logic [15:0] WeightOld = 16'd60293;
  localparam logic [15:0] WeightNew = 16'd5243;
  localparam logic [15:0] RoundHalf = 16'd32768;

  localparam logic [30:0] CountLimit [4] = '{31'd42000, 31'd55000, 31'd1000000, 31'd10000000};

  typedef struct packed {
    logic               action;
    logic [31:0]        frame_index;
    logic signed [31:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  load_level;
    logic        simulation_allowed;
    logic [2:0]  cadence_multiplier;
    logic [6:0]  nav_interval;
    logic [6:0]  command_limit;
    logic [31:0] sample_total;
    logic [38:0] average_time;
    logic [30:0] peak_time_us;
    logic [31:0] count_over_42ms;
    logic [31:0] count_over_55ms;
    logic [31:0] count_over_1s;
    logic [31:0] count_over_10s;
  } out_item_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic logic [31:0] extend_deadline(input logic [31:0] old_dl,
                                                  input logic [31:0] frame,
                                                  input logic [15:0] hold);
    logic [32:0] sum;
    logic [31:0] cand;
    sum  = {1'b0, frame} + {17'd0, hold};
    cand = sum[32] ? '1 : sum[31:0];
    return (cand > old_dl) ? cand : old_dl;
  endfunction

  function automatic logic [2:0] cadence_of(input load_level_e lvl);
    case (lvl)
      LVL_REDUCED:   return 3'd2;
      LVL_EMERGENCY: return 3'd4;
      default:       return 3'd1;
    endcase
  endfunction

  function automatic logic [6:0] nav_of(input load_level_e lvl);
    case (lvl)
      LVL_REDUCED:   return 7'd48;
      LVL_EMERGENCY: return 7'd96;
      default:       return 7'd24;
    endcase
  endfunction

  function automatic logic [6:0] cmd_of(input load_level_e lvl);
    case (lvl)
      LVL_REDUCED:   return 7'd64;
      LVL_EMERGENCY: return 7'd40;
      default:       return 7'd96;
    endcase
  endfunction

endpackage

[hdl/frame_load_governor.sv]
// ----------------------------------------------------------------------------
// frame_load_governor
// Frame time statistics and load level with hold deadlines.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one beat per
//   frame: a record (action 0) with a frame time, or a query (action 1).
//   Output channel (out_valid_o / out_stall_i / out_item_o) returns one beat
//   per input beat, in order: level, derived cadence settings, statistics.
//   The path runs through an input register, then a result register. One
//   beat per cycle is sustained while the receiver does not stall; the
//   update of average, counters and deadlines for a beat is combinational
//   between the two registers, so the next beat sees the updated state.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_stall_o rises once both are occupied.
//   Reset clears statistics, deadlines and both valid flags and loads the
//   default thresholds and hold lengths. The user writes registers (APB byte
//   offsets 0x00 to 0x14) only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module frame_load_governor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  flg_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output flg_pkg::out_item_t  out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [flg_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import flg_pkg::*;

  logic [30:0] emerg_thr_q, reduced_thr_q, avg_thr_q;
  logic [15:0] emerg_hold_q, long_hold_q, short_hold_q;

  logic        s1_valid_q;
  in_item_t    s1_item_q;
  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;

  logic [31:0] cnt_q, cnt_d;
  logic [38:0] avg_q, avg_d;
  logic [30:0] peak_q, peak_d;
  logic [31:0] thr_cnt_q [4];
  logic [31:0] thr_cnt_d [4];
  logic [31:0] emerg_dl_q, emerg_dl_d;
  logic [31:0] reduced_dl_q, reduced_dl_d;

  logic        advance;
  logic        cfg_wr;
  cfg_reg_e    cfg_sel;
  logic        is_record;
  logic [30:0] us;
  logic [55:0] mix;
  logic        hit_emerg, hit_reduced;
  load_level_e lvl;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emerg_thr_q   <= EmergThrReset;
      reduced_thr_q <= ReducedThrReset;
      avg_thr_q     <= AvgThrReset;
      emerg_hold_q  <= EmergHoldReset;
      long_hold_q   <= LongHoldReset;
      short_hold_q  <= ShortHoldReset;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_EMERG_THR:   emerg_thr_q   <= pwdata[30:0];
        REG_REDUCED_THR: reduced_thr_q <= pwdata[30:0];
        REG_AVG_THR:     avg_thr_q     <= pwdata[30:0];
        REG_EMERG_HOLD:  emerg_hold_q  <= pwdata[15:0];
        REG_LONG_HOLD:   long_hold_q   <= pwdata[15:0];
        REG_SHORT_HOLD:  short_hold_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_EMERG_THR:   prdata = {1'b0, emerg_thr_q};
      REG_REDUCED_THR: prdata = {1'b0, reduced_thr_q};
      REG_AVG_THR:     prdata = {1'b0, avg_thr_q};
      REG_EMERG_HOLD:  prdata = {16'd0, emerg_hold_q};
      REG_LONG_HOLD:   prdata = {16'd0, long_hold_q};
      REG_SHORT_HOLD:  prdata = {16'd0, short_hold_q};
      default:         prdata = '0;
    endcase
  end

  // advance the input beat into the result register
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_item_q <= in_item_i;
    end
    if (advance && s1_valid_q) begin
      out_item_q <= out_item_d;
    end
  end

  always_comb begin
    is_record = !s1_item_q.action;
    us        = s1_item_q.elapsed_us[31] ? '0 : s1_item_q.elapsed_us[30:0];
    mix       = 56'(avg_q) * 56'(WeightOld) + 56'({us, 8'h00}) * 56'(WeightNew)
              + 56'(RoundHalf);

    cnt_d        = cnt_q;
    avg_d        = avg_q;
    peak_d       = peak_q;
    emerg_dl_d   = emerg_dl_q;
    reduced_dl_d = reduced_dl_q;
    for (int i = 0; i < 4; i++) begin
      thr_cnt_d[i] = thr_cnt_q[i];
    end
    hit_emerg   = 1'b0;
    hit_reduced = 1'b0;

    if (is_record) begin
      avg_d  = (cnt_q == '0) ? {us, 8'h00} : mix[54:16];
      cnt_d  = sat_inc(cnt_q);
      peak_d = (us > peak_q) ? us : peak_q;
      for (int i = 0; i < 4; i++) begin
        if (us >= CountLimit[i]) begin
          thr_cnt_d[i] = sat_inc(thr_cnt_q[i]);
        end
      end
      hit_emerg   = us >= emerg_thr_q;
      hit_reduced = (us >= reduced_thr_q) || (avg_d >= {avg_thr_q, 8'h00});
      if (hit_emerg) begin
        emerg_dl_d   = extend_deadline(emerg_dl_q, s1_item_q.frame_index, emerg_hold_q);
        reduced_dl_d = extend_deadline(reduced_dl_q, s1_item_q.frame_index, long_hold_q);
      end else if (hit_reduced) begin
        reduced_dl_d = extend_deadline(reduced_dl_q, s1_item_q.frame_index, short_hold_q);
      end
    end

    if (s1_item_q.frame_index < emerg_dl_d) begin
      lvl = LVL_EMERGENCY;
    end else if (s1_item_q.frame_index < reduced_dl_d) begin
      lvl = LVL_REDUCED;
    end else begin
      lvl = LVL_NORMAL;
    end

    out_item_d.load_level         = lvl;
    out_item_d.simulation_allowed = (lvl == LVL_NORMAL);
    out_item_d.cadence_multiplier = cadence_of(lvl);
    out_item_d.nav_interval       = nav_of(lvl);
    out_item_d.command_limit      = cmd_of(lvl);
    out_item_d.sample_total       = cnt_d;
    out_item_d.average_time       = avg_d;
    out_item_d.peak_time_us       = peak_d;
    out_item_d.count_over_42ms    = thr_cnt_d[0];
    out_item_d.count_over_55ms    = thr_cnt_d[1];
    out_item_d.count_over_1s      = thr_cnt_d[2];
    out_item_d.count_over_10s     = thr_cnt_d[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      avg_q        <= '0;
      peak_q       <= '0;
      emerg_dl_q   <= '0;
      reduced_dl_q <= '0;
      for (int i = 0; i < 4; i++) begin
        thr_cnt_q[i] <= '0;
      end
    end else if (advance && s1_valid_q) begin
      cnt_q        <= cnt_d;
      avg_q        <= avg_d;
      peak_q       <= peak_d;
      emerg_dl_q   <= emerg_dl_d;
      reduced_dl_q <= reduced_dl_d;
      for (int i = 0; i < 4; i++) begin
        thr_cnt_q[i] <= thr_cnt_d[i];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_cnt_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q >= $past(cnt_q))
    else $error("sample count decreased");

  a_deadline_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (emerg_dl_q >= $past(emerg_dl_q)) && (reduced_dl_q >= $past(reduced_dl_q)))
    else $error("hold deadline moved back");

  a_state_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && s1_valid_q) |=> $stable(cnt_q) && $stable(avg_q) && $stable(emerg_dl_q))
    else $error("state changed without a beat");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with free stage");

endmodule

[test/frame_load_governor_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_load_governor_tb
// Self-checking bench for the frame load governor. Frame beats (records and
// queries) are offered with random gaps while the result side stalls at
// random. An in-bench predictor keeps its own copy of the statistics, hold
// deadlines and registers and checks every result beat field by field, in
// order. Register writes go through the APB port between phases and are read
// back. Phases cover edge values, default traffic, random settings, a long
// receiver hold-off, register extremes and deadline saturation.
// ----------------------------------------------------------------------------
module frame_load_governor_tb;
  import flg_pkg::*;

  localparam logic ActRecord = 1'b0;
  localparam logic ActQuery  = 1'b1;

  localparam logic [AddrWidth-1:0] UnmappedAddr = AddrWidth'(5'h18);

  localparam logic [63:0] AvgKeepQ16  = 64'd60293;
  localparam logic [63:0] AvgTakeQ16  = 64'd5243;
  localparam logic [63:0] AvgRoundQ16 = 64'd32768;
  localparam logic [3:0][30:0] OverLimit = {31'd10000000, 31'd1000000, 31'd55000, 31'd42000};

  localparam int SettleCycles  = 6;
  localparam int HoldOffCycles = 120;
  localparam int IdleLimit     = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_item_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // register copy
  logic [30:0] emerg_thr   = 31'd40000;
  logic [30:0] reduced_thr = 31'd28000;
  logic [30:0] avg_thr     = 31'd20000;
  logic [15:0] emerg_hold  = 16'd192;
  logic [15:0] long_hold   = 16'd360;
  logic [15:0] short_hold  = 16'd192;

  // statistics and deadlines
  logic [31:0] samples_seen  = '0;
  logic [38:0] avg_q         = '0;
  logic [30:0] peak_us       = '0;
  logic [31:0] over_count [4] = '{default: '0};
  logic [31:0] emerg_until   = '0;
  logic [31:0] reduced_until = '0;

  out_item_t   pending_reports [$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          tx_idle_max = 0;
  int          rx_idle_max = 0;
  bit          hold_off_req = 1'b0;
  logic [31:0] frame_now = '0;

  frame_load_governor uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [31:0] count_up(logic [31:0] v);
    return v + {31'd0, ~&v};
  endfunction

  function automatic logic [31:0] push_deadline(logic [31:0] old_dl, logic [31:0] frame,
                                                logic [15:0] hold);
    logic [32:0] reach;
    reach = {1'b0, frame} + {17'd0, hold};
    if (reach[32]) reach = {1'b0, 32'hFFFF_FFFF};
    return (reach[31:0] > old_dl) ? reach[31:0] : old_dl;
  endfunction

  function automatic out_item_t predict_report(in_item_t b);
    out_item_t   r;
    logic [30:0] us;
    logic [38:0] sample;
    logic [63:0] mix;
    load_level_e lvl;
    if (b.action == ActRecord) begin
      us = b.elapsed_us[31] ? 31'd0 : b.elapsed_us[30:0];
      sample = {us, 8'd0};
      if (samples_seen == 32'd0) begin
        avg_q = sample;
      end else begin
        mix = 64'(avg_q) * AvgKeepQ16 + 64'(sample) * AvgTakeQ16 + AvgRoundQ16;
        avg_q = mix[54:16];
      end
      samples_seen = count_up(samples_seen);
      if (us > peak_us) peak_us = us;
      for (int i = 0; i < 4; i++)
        if (us >= OverLimit[i]) over_count[i] = count_up(over_count[i]);
      if (us >= emerg_thr) begin
        emerg_until   = push_deadline(emerg_until, b.frame_index, emerg_hold);
        reduced_until = push_deadline(reduced_until, b.frame_index, long_hold);
      end else if (us >= reduced_thr || avg_q >= {avg_thr, 8'd0}) begin
        reduced_until = push_deadline(reduced_until, b.frame_index, short_hold);
      end
    end
    if (b.frame_index < emerg_until) lvl = LVL_EMERGENCY;
    else if (b.frame_index < reduced_until) lvl = LVL_REDUCED;
    else lvl = LVL_NORMAL;
    r.load_level = lvl;
    r.simulation_allowed = (lvl == LVL_NORMAL);
    case (lvl)
      LVL_EMERGENCY: begin
        r.cadence_multiplier = 3'd4;
        r.nav_interval = 7'd96;
        r.command_limit = 7'd40;
      end
      LVL_REDUCED: begin
        r.cadence_multiplier = 3'd2;
        r.nav_interval = 7'd48;
        r.command_limit = 7'd64;
      end
      default: begin
        r.cadence_multiplier = 3'd1;
        r.nav_interval = 7'd24;
        r.command_limit = 7'd96;
      end
    endcase
    r.sample_total    = samples_seen;
    r.average_time    = avg_q;
    r.peak_time_us    = peak_us;
    r.count_over_42ms = over_count[0];
    r.count_over_55ms = over_count[1];
    r.count_over_1s   = over_count[2];
    r.count_over_10s  = over_count[3];
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic logic [31:0] reg_value(cfg_reg_e r);
    case (r)
      REG_EMERG_THR:   return {1'b0, emerg_thr};
      REG_REDUCED_THR: return {1'b0, reduced_thr};
      REG_AVG_THR:     return {1'b0, avg_thr};
      REG_EMERG_HOLD:  return {16'd0, emerg_hold};
      REG_LONG_HOLD:   return {16'd0, long_hold};
      default:         return {16'd0, short_hold};
    endcase
  endfunction

  function automatic logic [AddrWidth-1:0] reg_addr(cfg_reg_e r);
    return AddrWidth'({r, 2'b00});
  endfunction

  always @(posedge clk_i) begin : beat_monitor
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) pending_reports.push_back(predict_report(in_item_i));
      if (out_valid_o && !out_stall_i) begin
        if (pending_reports.size() == 0) begin
          $display("%0t result beat with no expected report, actual %0h", $time, out_item_o);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          check_field("load_level", 64'(want.load_level), 64'(out_item_o.load_level));
          check_field("simulation_allowed", 64'(want.simulation_allowed),
                      64'(out_item_o.simulation_allowed));
          check_field("cadence_multiplier", 64'(want.cadence_multiplier),
                      64'(out_item_o.cadence_multiplier));
          check_field("nav_interval", 64'(want.nav_interval),
                      64'(out_item_o.nav_interval));
          check_field("command_limit", 64'(want.command_limit),
                      64'(out_item_o.command_limit));
          check_field("sample_total", 64'(want.sample_total),
                      64'(out_item_o.sample_total));
          check_field("average_time", 64'(want.average_time),
                      64'(out_item_o.average_time));
          check_field("peak_time_us", 64'(want.peak_time_us),
                      64'(out_item_o.peak_time_us));
          check_field("count_over_42ms", 64'(want.count_over_42ms),
                      64'(out_item_o.count_over_42ms));
          check_field("count_over_55ms", 64'(want.count_over_55ms),
                      64'(out_item_o.count_over_55ms));
          check_field("count_over_1s", 64'(want.count_over_1s),
                      64'(out_item_o.count_over_1s));
          check_field("count_over_10s", 64'(want.count_over_10s),
                      64'(out_item_o.count_over_10s));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t no beat moved for %0d cycles", $time, IdleLimit);
        $display("frame_load_governor verification failed");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int wait_cycles;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      wait_cycles = $urandom_range(0, rx_idle_max);
      if (hold_off_req) begin
        // hold off long enough to fill the block and stall the sender
        wait_cycles = HoldOffCycles;
        hold_off_req = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_frame(logic act, logic [31:0] frame, logic [31:0] elapsed);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{action: act, frame_index: frame, elapsed_us: elapsed};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(logic write_en, logic [AddrWidth-1:0] addr, logic [31:0] data,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void check_readback(cfg_reg_e r, logic [31:0] rdata);
    if (rdata !== reg_value(r)) begin
      $display("%0t register %s expected %0h actual %0h", $time, r.name(), reg_value(r),
               rdata);
      errors++;
    end
  endfunction

  task automatic write_reg(cfg_reg_e r, logic [31:0] v);
    logic [31:0] rdata;
    apb_access(1'b1, reg_addr(r), v, rdata);
    case (r)
      REG_EMERG_THR:   emerg_thr   = v[30:0];
      REG_REDUCED_THR: reduced_thr = v[30:0];
      REG_AVG_THR:     avg_thr     = v[30:0];
      REG_EMERG_HOLD:  emerg_hold  = v[15:0];
      REG_LONG_HOLD:   long_hold   = v[15:0];
      default:         short_hold  = v[15:0];
    endcase
    apb_access(1'b0, reg_addr(r), '0, rdata);
    check_readback(r, rdata);
  endtask

  task automatic check_all_regs();
    logic [31:0] rdata;
    for (int i = 0; i <= int'(REG_SHORT_HOLD); i++) begin
      apb_access(1'b0, reg_addr(cfg_reg_e'(i)), '0, rdata);
      check_readback(cfg_reg_e'(i), rdata);
    end
  endtask

  task automatic run_traffic(int count, bit wide);
    logic        act;
    logic [31:0] frame;
    logic [31:0] elapsed;
    repeat (count) begin
      act = ($urandom_range(0, 3) == 0) ? ActQuery : ActRecord;
      if (wide) begin
        frame   = $urandom;
        elapsed = $urandom;
      end else begin
        frame_now += ($urandom_range(0, 9) == 0) ? $urandom_range(50, 600)
                                                 : $urandom_range(0, 3);
        frame = frame_now;
        if (act == ActQuery && $urandom_range(0, 3) == 0) frame -= $urandom_range(0, 20);
        case ($urandom_range(0, 19))
          0: elapsed = {1'b1, 31'($urandom)};
          1: elapsed = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(100000, 1000000);
          2: begin
            case ($urandom_range(0, 6))
              0: elapsed = {1'b0, emerg_thr};
              1: elapsed = {1'b0, reduced_thr};
              2: elapsed = {1'b0, avg_thr};
              3: elapsed = 32'd42000;
              4: elapsed = 32'd55000;
              5: elapsed = 32'd1000000;
              default: elapsed = 32'd10000000;
            endcase
            elapsed -= $urandom_range(0, 1);
          end
          3, 4, 5: elapsed = $urandom_range(20000, 60000);
          default: elapsed = $urandom_range(0, 22000);
        endcase
      end
      send_frame(act, frame, elapsed);
    end
  endtask

  task automatic test_directed_edges();
    tx_idle_max = 3;
    rx_idle_max = 3;
    send_frame(ActQuery, 32'd0, 32'd0);
    send_frame(ActRecord, 32'd1, 32'd1000);
    send_frame(ActRecord, 32'd2, 32'hFFFF_FFFF);
    send_frame(ActRecord, 32'd3, 32'h8000_0000);
    send_frame(ActRecord, 32'd4, 32'd27999);
    send_frame(ActQuery, 32'd5, 32'h7FFF_FFFF);
    send_frame(ActRecord, 32'd6, 32'd28000);
    send_frame(ActQuery, 32'd197, 32'd0);
    send_frame(ActQuery, 32'd198, 32'd0);
    send_frame(ActRecord, 32'd200, 32'd39999);
    send_frame(ActRecord, 32'd201, 32'd40000);
    send_frame(ActQuery, 32'd392, 32'd0);
    send_frame(ActQuery, 32'd393, 32'd0);
    send_frame(ActQuery, 32'd561, 32'd0);
    send_frame(ActRecord, 32'd600, 32'd41999);
    send_frame(ActRecord, 32'd601, 32'd42000);
    send_frame(ActRecord, 32'd602, 32'd55000);
    send_frame(ActRecord, 32'd603, 32'd999999);
    send_frame(ActRecord, 32'd604, 32'd1000000);
    send_frame(ActRecord, 32'd605, 32'd10000000);
    send_frame(ActRecord, 32'd606, 32'h7FFF_FFFF);
    // fast frame while the average is still high
    send_frame(ActRecord, 32'd2000, 32'd0);
    send_frame(ActQuery, 32'd2191, 32'd0);
    send_frame(ActQuery, 32'd2192, 32'd0);
    frame_now = 32'd3000;
  endtask

  task automatic test_default_traffic();
    tx_idle_max = 15;
    rx_idle_max = 15;
    run_traffic(150, 1'b0);
  endtask

  task automatic test_random_settings();
    settle();
    write_reg(REG_EMERG_THR, $urandom_range(25000, 60000));
    write_reg(REG_REDUCED_THR, $urandom_range(10000, 40000));
    write_reg(REG_AVG_THR, $urandom_range(5000, 30000));
    write_reg(REG_EMERG_HOLD, $urandom_range(0, 40));
    write_reg(REG_LONG_HOLD, $urandom_range(0, 40));
    write_reg(REG_SHORT_HOLD, $urandom_range(0, 40));
    tx_idle_max = 0;
    rx_idle_max = 0;
    run_traffic(60, 1'b0);
    tx_idle_max = 15;
    rx_idle_max = 2;
    run_traffic(40, 1'b0);
  endtask

  task automatic test_backpressure();
    tx_idle_max = 0;
    rx_idle_max = 3;
    hold_off_req = 1'b1;
    run_traffic(30, 1'b0);
  endtask

  task automatic test_config_extremes();
    logic [31:0] rdata;
    settle();
    write_reg(REG_EMERG_THR, 32'd0);
    write_reg(REG_REDUCED_THR, 32'd0);
    write_reg(REG_AVG_THR, 32'd0);
    write_reg(REG_EMERG_HOLD, 32'd0);
    write_reg(REG_LONG_HOLD, 32'd0);
    write_reg(REG_SHORT_HOLD, 32'd0);
    tx_idle_max = 15;
    rx_idle_max = 15;
    run_traffic(20, 1'b0);
    settle();
    // drop a write past the last register
    apb_access(1'b1, UnmappedAddr, 32'hFFFF_FFFF, rdata);
    check_all_regs();
    write_reg(REG_EMERG_THR, 32'hFFFF_FFFF);
    write_reg(REG_REDUCED_THR, 32'hFFFF_FFFF);
    write_reg(REG_AVG_THR, 32'hFFFF_FFFF);
    write_reg(REG_EMERG_HOLD, 32'hFFFF_FFFF);
    write_reg(REG_LONG_HOLD, 32'hFFFF_FFFF);
    write_reg(REG_SHORT_HOLD, 32'hFFFF_FFFF);
    frame_now += 32'd1;
    send_frame(ActRecord, frame_now, 32'h7FFF_FFFF);
    run_traffic(25, 1'b0);
  endtask

  task automatic test_deadline_saturation();
    settle();
    write_reg(REG_EMERG_THR, 32'd40000);
    write_reg(REG_EMERG_HOLD, 32'd65535);
    tx_idle_max = 15;
    rx_idle_max = 15;
    send_frame(ActRecord, 32'hFFFF_FFFF, 32'd50000);
    send_frame(ActQuery, 32'hFFFF_FFFE, 32'd0);
    send_frame(ActQuery, 32'hFFFF_FFFF, 32'd0);
    run_traffic(50, 1'b1);
  endtask

  initial begin : sequencer
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_all_regs();
    test_directed_edges();
    test_default_traffic();
    test_random_settings();
    test_backpressure();
    test_config_extremes();
    test_deadline_saturation();
    settle();
    if (errors == 0) begin
      $display("frame_load_governor verification clean");
    end else begin
      $display("frame_load_governor verification failed");
    end
    $finish;
  end

endmodule
